@@ rtl/pss_pkg.sv @@
// Shared types and constants for the periodic subscription scheduler.
package pss_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned CMD_W    = 1;
    localparam int unsigned SLOTNUM_W = 8;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned COUNT_W  = 2;
    localparam int unsigned BUSID_W  = 5;
    localparam int unsigned OFFSET_W = 10;

    // A period of all ones never fires.
    localparam logic [PERIOD_W-1:0] PERIOD_OFF = '1;

    // At most this many slots are reported in one pass.
    localparam logic [COUNT_W-1:0] MAX_REPORTS = 2'd2;

    // Pass command codes.
    localparam logic [CMD_W-1:0] CMD_TICK      = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SUBSCRIBE = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pass;   // capture the accepted pass
        logic setup;       // apply subscribe, flip channel, restart walk
        logic step;        // advance one slot counter
        logic load_out;    // move the pass result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic abort;       // subscribe to a slot number out of range
        logic last_slot;   // walk index is at the final slot
        logic any_due;     // at least one slot was reported in this pass
        logic out_free;    // output register can take a new result
    } dp_status_t;

endpackage

@@ rtl/pss_ctrl.sv @@
// Controller state machine for the periodic subscription scheduler.
module pss_ctrl
    import pss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pass_valid,
    output logic       pass_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pass_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                pass_stall = 1'b0;
                if (pass_valid)
                begin
                    cmd.load_pass = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.abort)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.any_due)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pss_datapath.sv @@
// Slot tables, counter walk and result register of the periodic subscription scheduler.
module pss_datapath
    import pss_pkg::*;
#(
    parameter int unsigned SLOTS    = 16,
    parameter int unsigned ID_SHIFT = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd_in,
    output dp_status_t           status,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [SLOTNUM_W-1:0] slot_number,
    input  logic [PERIOD_W-1:0]  report_period,
    input  logic [ADDR_W-1:0]    data_address,
    output logic                 report_valid,
    input  logic                 report_stall,
    output logic [COUNT_W-1:0]   report_count,
    output logic [BUSID_W-1:0]   first_slot,
    output logic [ADDR_W-1:0]    first_address,
    output logic [BUSID_W-1:0]   second_slot,
    output logic [ADDR_W-1:0]    second_address,
    output logic [OFFSET_W-1:0]  id_offset,
    output logic                 alt_channel
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Captured pass.
    logic [CMD_W-1:0]     cmd_reg;
    logic [SLOTNUM_W-1:0] slot_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [ADDR_W-1:0]    addr_reg;

    // Slot tables.
    logic [PERIOD_W-1:0] period_table_reg [SLOTS];
    logic [PERIOD_W-1:0] tick_counter_reg [SLOTS];
    logic [ADDR_W-1:0]   address_table_reg [SLOTS];
    logic                toggle_reg;

    // Walk and per-pass results.
    logic [IDX_W-1:0]    idx_reg;
    logic [COUNT_W-1:0]  rep_count_reg;
    logic [BUSID_W-1:0]  first_id_reg;
    logic [ADDR_W-1:0]   first_addr_reg;
    logic [BUSID_W-1:0]  second_id_reg;
    logic [ADDR_W-1:0]   second_addr_reg;
    logic [OFFSET_W-1:0] offset_reg;

    // Output register.
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [BUSID_W-1:0]  out_first_id_reg;
    logic [ADDR_W-1:0]   out_first_addr_reg;
    logic [BUSID_W-1:0]  out_second_id_reg;
    logic [ADDR_W-1:0]   out_second_addr_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_channel_reg;

    logic                in_range;
    logic [IDX_W-1:0]    sub_idx;
    logic [SLOTNUM_W-1:0] slot_minus_one;
    logic [PERIOD_W-1:0] cnt_inc;
    logic                due;
    logic [BUSID_W-1:0]  bus_id;

    // Subscribe target and range check.
    assign in_range       = (slot_reg != '0) && (slot_reg <= SLOTNUM_W'(SLOTS));
    assign slot_minus_one = slot_reg - SLOTNUM_W'(1);
    assign sub_idx        = slot_minus_one[IDX_W-1:0];

    // Counter of the slot under the walk index.
    assign cnt_inc = tick_counter_reg[idx_reg] + PERIOD_W'(1);
    assign due     = (cnt_inc > period_table_reg[idx_reg]) && (rep_count_reg < MAX_REPORTS);
    assign bus_id  = BUSID_W'(idx_reg) + BUSID_W'(1);

    // Status toward the controller.
    assign status.abort     = (cmd_reg == CMD_SUBSCRIBE) && !in_range;
    assign status.last_slot = (idx_reg == LAST_IDX);
    assign status.any_due   = (rep_count_reg != '0);
    assign status.out_free  = !out_valid_reg || !report_stall;

    // Pass capture.
    always_ff @(posedge clk)
    begin
        if (cmd_in.load_pass)
        begin
            cmd_reg    <= cmd;
            slot_reg   <= slot_number;
            period_reg <= report_period;
            addr_reg   <= data_address;
        end
    end

    // Slot tables and channel toggle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                period_table_reg[i]  <= PERIOD_OFF;
                tick_counter_reg[i]  <= '0;
                address_table_reg[i] <= '0;
            end
            toggle_reg <= 1'b0;
        end
        else if (cmd_in.setup)
        begin
            toggle_reg <= ~toggle_reg;
            if (cmd_reg == CMD_SUBSCRIBE)
            begin
                period_table_reg[sub_idx]  <= period_reg;
                tick_counter_reg[sub_idx]  <= '0;
                address_table_reg[sub_idx] <= addr_reg;
            end
        end
        else if (cmd_in.step)
        begin
            tick_counter_reg[idx_reg] <= due ? PERIOD_W'(1) : cnt_inc;
        end
    end

    // Walk index and collection of the first two due slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rep_count_reg <= '0;
        end
        else if (cmd_in.setup)
        begin
            idx_reg       <= '0;
            rep_count_reg <= '0;
        end
        else if (cmd_in.step)
        begin
            if (!status.last_slot)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (due)
            begin
                rep_count_reg <= rep_count_reg + COUNT_W'(1);
            end
        end
    end

    // Report payload gathered during the walk.
    always_ff @(posedge clk)
    begin
        if (cmd_in.setup)
        begin
            first_id_reg    <= '0;
            first_addr_reg  <= '0;
            second_id_reg   <= '0;
            second_addr_reg <= '0;
            offset_reg      <= '0;
        end
        else if (cmd_in.step && due)
        begin
            if (rep_count_reg == '0)
            begin
                first_id_reg   <= bus_id;
                first_addr_reg <= address_table_reg[idx_reg];
                offset_reg     <= OFFSET_W'(bus_id);
            end
            else
            begin
                second_id_reg   <= bus_id;
                second_addr_reg <= address_table_reg[idx_reg];
                offset_reg      <= offset_reg + (OFFSET_W'(bus_id) << ID_SHIFT);
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_in.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!report_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd_in.load_out)
        begin
            out_count_reg       <= rep_count_reg;
            out_first_id_reg    <= first_id_reg;
            out_first_addr_reg  <= first_addr_reg;
            out_second_id_reg   <= second_id_reg;
            out_second_addr_reg <= second_addr_reg;
            out_offset_reg      <= offset_reg;
            out_channel_reg     <= toggle_reg;
        end
    end

    assign report_valid   = out_valid_reg;
    assign report_count   = out_count_reg;
    assign first_slot     = out_first_id_reg;
    assign first_address  = out_first_addr_reg;
    assign second_slot    = out_second_id_reg;
    assign second_address = out_second_addr_reg;
    assign id_offset      = out_offset_reg;
    assign alt_channel    = out_channel_reg;

endmodule

@@ rtl/periodic_subscription_scheduler.sv @@
// Top level of the periodic subscription scheduler.
//
//   Channel   Direction  Handshake            Carries
//   pass      in         pass_valid/stall     cmd, slot_number, report_period, data_address
//   report    out        report_valid/stall   count, slots, addresses, id_offset, alt_channel
//
// A pass is accepted, then the subscribe request is applied, then the counter
// walk visits every slot in turn, and finally the result is handed over.
// The walk visits the slot tables through a single index, one slot a cycle.
// A pass with an out-of-range subscribe ends at the setup state with no change.
// The result waits in an output register; a stalled report holds the next
// pass only in its finish state. Reset restores all slot tables at once.
module periodic_subscription_scheduler
    import pss_pkg::*;
#(
    parameter int unsigned SLOTS    = 16,
    parameter int unsigned ID_SHIFT = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pass_valid,
    output logic                 pass_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [SLOTNUM_W-1:0] slot_number,
    input  logic [PERIOD_W-1:0]  report_period,
    input  logic [ADDR_W-1:0]    data_address,
    output logic                 report_valid,
    input  logic                 report_stall,
    output logic [COUNT_W-1:0]   report_count,
    output logic [BUSID_W-1:0]   first_slot,
    output logic [ADDR_W-1:0]    first_address,
    output logic [BUSID_W-1:0]   second_slot,
    output logic [ADDR_W-1:0]    second_address,
    output logic [OFFSET_W-1:0]  id_offset,
    output logic                 alt_channel
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // Sequencing of one pass.
    pss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pass_valid (pass_valid),
        .pass_stall (pass_stall),
        .status     (dp_status),
        .cmd        (ctrl_cmd)
    );

    // Slot tables and result path.
    pss_datapath #(
        .SLOTS    (SLOTS),
        .ID_SHIFT (ID_SHIFT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_in         (ctrl_cmd),
        .status         (dp_status),
        .cmd            (cmd),
        .slot_number    (slot_number),
        .report_period  (report_period),
        .data_address   (data_address),
        .report_valid   (report_valid),
        .report_stall   (report_stall),
        .report_count   (report_count),
        .first_slot     (first_slot),
        .first_address  (first_address),
        .second_slot    (second_slot),
        .second_address (second_address),
        .id_offset      (id_offset),
        .alt_channel    (alt_channel)
    );

endmodule

@@ rtl/pss_checker.sv @@
// Port-level assertions for the periodic subscription scheduler, with its bind.
module pss_checker
    import pss_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pass_valid,
    input logic                 pass_stall,
    input logic                 report_valid,
    input logic                 report_stall,
    input logic [COUNT_W-1:0]   report_count,
    input logic [BUSID_W-1:0]   first_slot,
    input logic [BUSID_W-1:0]   second_slot,
    input logic [ADDR_W-1:0]    second_address
);

    // A stalled report stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=> report_valid)
        else $error("report dropped while stalled");

    // The block is busy right after taking a pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        pass_valid && !pass_stall |=> pass_stall)
        else $error("pass taken while previous pass still running");

    // A report carries one or two slots, the first always present.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> (report_count == 2'd1 || report_count == 2'd2) && first_slot != '0)
        else $error("report count or first slot out of range");

    // A single report leaves the second entry empty; a double one is in index order.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> (report_count == 2'd1 && second_slot == '0 && second_address == '0)
                      || (report_count == 2'd2 && second_slot > first_slot))
        else $error("second report entry inconsistent with count");

endmodule

bind periodic_subscription_scheduler pss_checker u_pss_checker (.*);

@@ dv/periodic_subscription_scheduler_test.sv @@
// Self-checking testbench for the periodic subscription scheduler.
`timescale 1ns / 1ps

module periodic_subscription_scheduler_test
    import pss_pkg::*;
;

    localparam int unsigned SLOTS    = 16;
    localparam int unsigned ID_SHIFT = 5;
    localparam int          RANDOM_PASSES = 700;
    localparam int          HOLD_OFF_CYCLES = 300;

    // One report transfer as seen on the output channel.
    typedef struct packed {
        logic [COUNT_W-1:0]  reported;
        logic [BUSID_W-1:0]  first_slot;
        logic [ADDR_W-1:0]   first_address;
        logic [BUSID_W-1:0]  second_slot;
        logic [ADDR_W-1:0]   second_address;
        logic [OFFSET_W-1:0] id_offset;
        logic                alt_channel;
    } report_t;

    // Slot table model plus the queue of reports it says are owed.
    class report_scoreboard;
        logic [PERIOD_W-1:0] period_tbl [SLOTS];
        logic [PERIOD_W-1:0] tick_cnt [SLOTS];
        logic [ADDR_W-1:0]   addr_tbl [SLOTS];
        logic                channel;
        report_t             owed_reports [$];
        int                  mismatches;

        // Power-up state: every slot disabled, counters and addresses cleared.
        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                period_tbl[i] = PERIOD_OFF;
                tick_cnt[i]   = '0;
                addr_tbl[i]   = '0;
            end
            channel    = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        // Advance the slot tables by one accepted pass and queue any report.
        function void note_pass(logic [CMD_W-1:0] op, logic [SLOTNUM_W-1:0] slot,
                                logic [PERIOD_W-1:0] period, logic [ADDR_W-1:0] addr);
            report_t     rpt;
            int          n;
            logic [31:0] ofs;
            rpt = '0;
            n   = 0;
            ofs = '0;
            if (op == CMD_SUBSCRIBE)
            begin
                // A bad slot number drops the whole pass.
                if (slot == 0 || slot > SLOTS)
                    return;
                addr_tbl[slot - 1]   = addr;
                period_tbl[slot - 1] = period;
                tick_cnt[slot - 1]   = '0;
            end
            channel = ~channel;
            // Walk the slots in order; only the first two due slots are served.
            for (int i = 0; i < SLOTS; i++)
            begin
                tick_cnt[i] = tick_cnt[i] + 16'd1;
                if (tick_cnt[i] > period_tbl[i] && n < MAX_REPORTS)
                begin
                    tick_cnt[i] = 16'd1;
                    if (n == 0)
                    begin
                        rpt.first_slot    = BUSID_W'(i + 1);
                        rpt.first_address = addr_tbl[i];
                    end
                    else
                    begin
                        rpt.second_slot    = BUSID_W'(i + 1);
                        rpt.second_address = addr_tbl[i];
                    end
                    ofs = ofs + (32'(i + 1) << (n * ID_SHIFT));
                    n++;
                end
            end
            if (n == 0)
                return;
            rpt.reported    = COUNT_W'(n);
            rpt.id_offset   = ofs[OFFSET_W-1:0];
            rpt.alt_channel = channel;
            owed_reports.push_back(rpt);
        endfunction

        // Print a mismatch line (for the first 100 only) and count it.
        task flag(string what);
            if (mismatches < 100)
                $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        // Compare one received report with the oldest owed one.
        task check_report(report_t got);
            report_t want;
            if (owed_reports.size() == 0)
            begin
                flag("report transfer with nothing owed");
                return;
            end
            want = owed_reports.pop_front();
            check_field("report_count", 32'(got.reported), 32'(want.reported));
            check_field("first_slot", 32'(got.first_slot), 32'(want.first_slot));
            check_field("first_address", got.first_address, want.first_address);
            check_field("second_slot", 32'(got.second_slot), 32'(want.second_slot));
            check_field("second_address", got.second_address, want.second_address);
            check_field("id_offset", 32'(got.id_offset), 32'(want.id_offset));
            check_field("alt_channel", 32'(got.alt_channel), 32'(want.alt_channel));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pass_valid = 1'b0;
    logic                 pass_stall;
    logic [CMD_W-1:0]     cmd = CMD_TICK;
    logic [SLOTNUM_W-1:0] slot_number = '0;
    logic [PERIOD_W-1:0]  report_period = '0;
    logic [ADDR_W-1:0]    data_address = '0;
    logic                 report_valid;
    logic                 report_stall = 1'b0;
    logic [COUNT_W-1:0]   report_count;
    logic [BUSID_W-1:0]   first_slot;
    logic [ADDR_W-1:0]    first_address;
    logic [BUSID_W-1:0]   second_slot;
    logic [ADDR_W-1:0]    second_address;
    logic [OFFSET_W-1:0]  id_offset;
    logic                 alt_channel;

    report_scoreboard sb = new();

    int passes_sent = 0;
    bit steady = 1'b0;
    bit out_of_reset = 1'b0;

    periodic_subscription_scheduler #(
        .SLOTS    (SLOTS),
        .ID_SHIFT (ID_SHIFT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pass_valid     (pass_valid),
        .pass_stall     (pass_stall),
        .cmd            (cmd),
        .slot_number    (slot_number),
        .report_period  (report_period),
        .data_address   (data_address),
        .report_valid   (report_valid),
        .report_stall   (report_stall),
        .report_count   (report_count),
        .first_slot     (first_slot),
        .first_address  (first_address),
        .second_slot    (second_slot),
        .second_address (second_address),
        .id_offset      (id_offset),
        .alt_channel    (alt_channel)
    );

    // 4 ns clock.
    always #2 clk = ~clk;

    // Offer one pass, hold it until the transfer, then maybe leave a gap.
    task automatic send_pass(input logic [CMD_W-1:0] op, input logic [SLOTNUM_W-1:0] slot,
                             input logic [PERIOD_W-1:0] period,
                             input logic [ADDR_W-1:0] addr);
        pass_valid    <= 1'b1;
        cmd           <= op;
        slot_number   <= slot;
        report_period <= period;
        data_address  <= addr;
        @(posedge clk);
        while (pass_stall)
            @(posedge clk);
        sb.note_pass(op, slot, period, addr);
        passes_sent++;
        // Gaps of varied length, outside the steady stretch, land at varied points of the slot walk.
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            pass_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    // Period mix weighted toward short periods so reports come often.
    function automatic logic [PERIOD_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return PERIOD_W'($urandom_range(0, 7));
        else if (roll < 75)
            return PERIOD_W'($urandom_range(8, 40));
        else if (roll < 87)
            return PERIOD_OFF;
        else
            return PERIOD_W'($urandom);
    endfunction

    // Report side: check each transfer and drive the stall for the next cycle.
    initial
    begin
        int  hold_left;
        bit  held_off;
        report_t got;
        hold_left = 0;
        held_off  = 1'b0;
        wait (out_of_reset);
        forever
        begin
            @(posedge clk);
            if (report_valid && !report_stall)
            begin
                got.reported       = report_count;
                got.first_slot     = first_slot;
                got.first_address  = first_address;
                got.second_slot    = second_slot;
                got.second_address = second_address;
                got.id_offset      = id_offset;
                got.alt_channel    = alt_channel;
                sb.check_report(got);
            end
            // One long hold-off so the block fills up and stalls its input.
            if (!held_off && passes_sent >= 450)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                report_stall <= 1'b1;
                hold_left--;
            end
            else if (steady)
                report_stall <= 1'b0;
            else
                report_stall <= ($urandom_range(0, 99) < 14);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int                   roll;
        logic [CMD_W-1:0]     op;
        logic [SLOTNUM_W-1:0] slot;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        out_of_reset = 1'b1;

        // Tick with every slot disabled; the payload of a tick is ignored.
        send_pass(CMD_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_pass(CMD_TICK, 8'h00, 16'h0000, 32'h0000_0000);
        // Out-of-range slot numbers abort the pass.
        send_pass(CMD_SUBSCRIBE, 8'd0, 16'd0, 32'hFFFF_FFFF);
        send_pass(CMD_SUBSCRIBE, 8'(SLOTS + 1), 16'd0, 32'h1234_5678);
        send_pass(CMD_SUBSCRIBE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        // Period zero fires on the subscribing pass; single report.
        send_pass(CMD_SUBSCRIBE, 8'd1, 16'd0, 32'hFFFF_FFFF);
        // Lowest and highest slot together give a double report.
        send_pass(CMD_SUBSCRIBE, 8'(SLOTS), 16'd0, 32'h0000_0000);
        // Three slots due at once: the last one is skipped and keeps counting.
        send_pass(CMD_SUBSCRIBE, 8'd8, 16'd0, 32'hA5A5_5A5A);
        send_pass(CMD_TICK, 8'd0, 16'd0, 32'd0);
        send_pass(CMD_TICK, 8'd0, 16'd0, 32'd0);
        // Disable slots again and use the largest enabled period.
        send_pass(CMD_SUBSCRIBE, 8'd1, PERIOD_OFF, 32'h0F0F_0F0F);
        send_pass(CMD_SUBSCRIBE, 8'd8, PERIOD_OFF, 32'hF0F0_F0F0);
        send_pass(CMD_SUBSCRIBE, 8'(SLOTS), 16'hFFFE, 32'h8000_0001);
        // A short period that repeats a few times.
        send_pass(CMD_SUBSCRIBE, 8'd5, 16'd3, 32'h7FFF_FFFE);
        repeat (6) send_pass(CMD_TICK, 8'd0, 16'd0, 32'd0);
        send_pass(CMD_SUBSCRIBE, 8'd5, 16'd1, 32'h5555_AAAA);
        repeat (3) send_pass(CMD_TICK, 8'd0, 16'd0, 32'd0);

        // Mostly valid subscribes and ticks, a little noise.
        for (int k = 0; k < RANDOM_PASSES; k++)
        begin
            steady = (k >= 250 && k < 350);
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                op   = CMD_SUBSCRIBE;
                slot = SLOTNUM_W'($urandom_range(1, SLOTS));
            end
            else if (roll < 93)
            begin
                op   = CMD_TICK;
                slot = SLOTNUM_W'($urandom_range(0, 255));
            end
            else
            begin
                op   = CMD_SUBSCRIBE;
                slot = ($urandom_range(0, 3) == 0) ? 8'd0
                     : SLOTNUM_W'($urandom_range(SLOTS + 1, 255));
            end
            send_pass(op, slot, pick_period(), ADDR_W'($urandom));
        end
        steady = 1'b0;
        pass_valid <= 1'b0;

        // Drain, then give the block time to show anything unexpected.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * (SLOTS + 3)) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag("reports still owed at end of run");
        if (sb.mismatches == 0)
            $display("periodic_subscription_scheduler regression: pass");
        else
            $display("periodic_subscription_scheduler regression: fail");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("periodic_subscription_scheduler regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pss_pkg.sv
rtl/pss_ctrl.sv
rtl/pss_datapath.sv
rtl/periodic_subscription_scheduler.sv
rtl/pss_checker.sv
dv/periodic_subscription_scheduler_test.sv
